// ===== hw/rtl/sbtc_pkg.sv =====
// shared constants, register indexes and arctangent table for the tone stage
// no dependencies
package sbtc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int STATE_WIDTH_DEF  = 40;

  localparam int GAIN_W     = 19;
  localparam int COEF_W     = 32;
  localparam int MUL_BW     = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC       = 30;

  // cordic datapath
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;

  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] LIMIT_Q30    = 34'sd1073731086;
  localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

  // register reset values
  localparam logic [GAIN_W-1:0]        GAIN_RST = 19'd65536;
  localparam logic signed [COEF_W-1:0] A0_RST   = 32'sd20646982;
  localparam logic signed [COEF_W-1:0] B1_RST   = -32'sd1612289921;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAIN  = 3'd0,
    REG_TREBLE_GAIN = 3'd1,
    REG_BASS_GAIN   = 3'd2,
    REG_TREBLE_A0   = 3'd3,
    REG_TREBLE_B1   = 3'd4,
    REG_BASS_A0     = 3'd5,
    REG_BASS_B1     = 3'd6
  } cfg_idx_t;

  // truncated arctangent of 2^-i in q.30
  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000007;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/sbtc_smul.sv =====
// bit-serial signed multiplier, one multiplier bit per cycle
// uses sbtc_pkg for the multiplier operand width
module sbtc_smul #(
  parameter int AW = sbtc_pkg::STATE_WIDTH_DEF + 2
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   go,
  input  logic signed [AW-1:0]                   a,
  input  logic signed [sbtc_pkg::MUL_BW-1:0]     b,
  output logic                                   done,
  output logic signed [AW+sbtc_pkg::MUL_BW-1:0]  prod
);

  localparam int BW = sbtc_pkg::MUL_BW;
  localparam int PW = AW + BW;
  localparam int CNT_W = $clog2(BW);

  logic signed [PW-1:0] acc_r;
  logic signed [PW-1:0] mc_r;
  logic [BW-1:0]        mp_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add, top bit carries negative weight
  always_ff @(posedge clk) begin
    if (go) begin
      acc_r <= '0;
      mc_r  <= PW'(a);
      mp_r  <= b;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        if (cnt_r == CNT_W'(BW - 1)) begin
          acc_r <= acc_r - mc_r;
        end else begin
          acc_r <= acc_r + mc_r;
        end
      end
      mc_r <= mc_r <<< 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/stereo_baxandall_tone_stage_top.sv =====
// stereo tone stage: sine drive, two lowpass biquads, gain mix, arcsine
// uses sbtc_pkg and sbtc_smul
// work per channel: ten products on the bit-serial multiplier, 30 sine steps,
//   31 root steps and 30 arcsine steps; one pair is processed at a time
// flow: the next request is taken while a result waits in the output register
// reset: synchronous active low; clears control, filter state and registers
module stereo_baxandall_tone_stage_top #(
  parameter int SAMPLE_WIDTH = sbtc_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = sbtc_pkg::STATE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_right_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0]       out_right_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sbtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbtc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW   = sbtc_pkg::CORDIC_W;
  localparam int BW   = sbtc_pkg::MUL_BW;
  localparam int GW   = sbtc_pkg::GAIN_W;
  localparam int KW   = sbtc_pkg::COEF_W;
  localparam int AW   = STATE_WIDTH + 2;
  localparam int PW   = AW + BW;
  localparam int IW   = STATE_WIDTH + 4;
  localparam int SUMW = STATE_WIDTH + 6;
  localparam int OSH  = 32 - SAMPLE_WIDTH;
  localparam int DSH  = SAMPLE_WIDTH - 15;
  localparam int RW   = 62;

  localparam logic signed [IW-1:0] ST_MAX = IW'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [IW-1:0] ST_MIN = -ST_MAX - IW'(1);
  localparam logic signed [CW-1:0] OUT_MAX = CW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] OUT_MIN = -OUT_MAX - CW'(1);
  localparam logic signed [CW-1:0] RND =
    (OSH > 0) ? (CW'(1) <<< ((OSH > 0) ? OSH - 1 : 0)) : '0;
  localparam logic signed [PW-1:0] DRV_MAX = PW'(sbtc_pkg::HALF_PI_Q30);
  localparam logic signed [PW-1:0] DRV_MIN = -DRV_MAX;
  localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'(sbtc_pkg::LIMIT_Q30);
  localparam logic signed [SUMW-1:0] SUM_MIN = -SUM_MAX;
  localparam logic [RW-1:0] ONE_Q60 = RW'(1) << 60;
  localparam logic signed [34:0] ONE_Q30_W = 35'sd1073741824;
  localparam logic signed [34:0] B2_MAX = 35'sd2147483647;
  localparam logic signed [34:0] B2_MIN = -35'sd2147483648;
  localparam logic [sbtc_pkg::STEP_W-1:0] LAST_STEP =
    sbtc_pkg::STEP_W'(sbtc_pkg::CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DRIVE, S_SIN, S_LP_P, S_LP_Y1, S_LP_Y2,
    S_GAIN, S_SQ, S_SQRT, S_ASIN, S_WAIT
  } state_t;

  function automatic logic signed [STATE_WIDTH-1:0] sat_st(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] r;
    r = v;
    if (v > ST_MAX) r = ST_MAX;
    if (v < ST_MIN) r = ST_MIN;
    return r[STATE_WIDTH-1:0];
  endfunction

  // configuration registers
  logic [GW-1:0]        ig_r, tg_r, bg_r;
  logic signed [KW-1:0] ta0_r, tb1_r, ba0_r, bb1_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ig_r  <= sbtc_pkg::GAIN_RST;
      tg_r  <= sbtc_pkg::GAIN_RST;
      bg_r  <= sbtc_pkg::GAIN_RST;
      ta0_r <= sbtc_pkg::A0_RST;
      tb1_r <= sbtc_pkg::B1_RST;
      ba0_r <= sbtc_pkg::A0_RST;
      bb1_r <= sbtc_pkg::B1_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbtc_pkg::REG_INPUT_GAIN:  ig_r  <= cfg_data[GW-1:0];
        sbtc_pkg::REG_TREBLE_GAIN: tg_r  <= cfg_data[GW-1:0];
        sbtc_pkg::REG_BASS_GAIN:   bg_r  <= cfg_data[GW-1:0];
        sbtc_pkg::REG_TREBLE_A0:   ta0_r <= $signed(cfg_data[KW-1:0]);
        sbtc_pkg::REG_TREBLE_B1:   tb1_r <= $signed(cfg_data[KW-1:0]);
        sbtc_pkg::REG_BASS_A0:     ba0_r <= $signed(cfg_data[KW-1:0]);
        sbtc_pkg::REG_BASS_B1:     bb1_r <= $signed(cfg_data[KW-1:0]);
        default: ;
      endcase
    end
  end

  // control and datapath registers
  state_t state_r;
  logic   ch_r, fsel_r, gsel_r, tog_r, out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] xl_r, xr_r, ol_r, or_r, left_out_r, right_out_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r, s_r, sc_r;
  logic [sbtc_pkg::STEP_W-1:0] it_r;
  logic signed [STATE_WIDTH-1:0] y_r, lh_r, lb_r, rd0_r, rd1_r;
  logic signed [PW-1:0] p_r;
  logic signed [SUMW-1:0] sum_r;
  logic [RW-1:0] n_r, res_r, bit_r;

  // shared serial multiplier
  logic                 mul_go_r;
  logic signed [AW-1:0] mul_a_r;
  logic signed [BW-1:0] mul_b_r;
  logic                 mul_done;
  logic signed [PW-1:0] mul_prod;

  sbtc_smul #(.AW(AW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // coefficient selection and derived b2
  logic signed [KW-1:0] a0_sel, b1_sel, b2_sel;
  logic signed [34:0]   b2_w;

  always_comb begin
    a0_sel = fsel_r ? ba0_r : ta0_r;
    b1_sel = fsel_r ? bb1_r : tb1_r;
    b2_w   = (35'(a0_sel) <<< 2) - ONE_Q30_W - 35'(b1_sel);
    if (b2_w > B2_MAX) begin
      b2_sel = B2_MAX[KW-1:0];
    end else if (b2_w < B2_MIN) begin
      b2_sel = B2_MIN[KW-1:0];
    end else begin
      b2_sel = b2_w[KW-1:0];
    end
  end

  // filter state memory: {filter, bank, channel, stage}
  logic signed [STATE_WIDTH-1:0] st_mem [16];
  logic [15:0]                   st_vld_r;
  logic                          mem_we;
  logic [3:0]                    mem_wa, rd_a0, rd_a1;
  logic signed [STATE_WIDTH-1:0] mem_wd, st0_nxt, st1_nxt, y_nxt;

  assign rd_a0 = {fsel_r, ~tog_r, ch_r, 1'b0};
  assign rd_a1 = {fsel_r, ~tog_r, ch_r, 1'b1};

  always_comb begin
    y_nxt   = sat_st(IW'(mul_prod >>> 30) + IW'(rd0_r));
    st0_nxt = sat_st(IW'(p_r >>> 29) - IW'(mul_prod >>> 30) + IW'(rd1_r));
    st1_nxt = sat_st(IW'(p_r >>> 30) - IW'(mul_prod >>> 30));
    mem_we  = 1'b0;
    mem_wa  = rd_a0;
    mem_wd  = st0_nxt;
    if (state_r == S_LP_Y1 && mul_done) begin
      mem_we = 1'b1;
    end
    if (state_r == S_LP_Y2 && mul_done) begin
      mem_we = 1'b1;
      mem_wa = rd_a1;
      mem_wd = st1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      st_mem[mem_wa] <= mem_wd;
    end
    rd0_r <= st_vld_r[rd_a0] ? st_mem[rd_a0] : '0;
    rd1_r <= st_vld_r[rd_a1] ? st_mem[rd_a1] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
    end else if (mem_we) begin
      st_vld_r[mem_wa] <= 1'b1;
    end
  end

  // cordic step, rotation for sine and vectoring for arcsine
  logic signed [CW-1:0] dx, dy, at, cx_nxt, cy_nxt, cz_nxt;

  always_comb begin
    dx = cy_r >>> it_r;
    dy = cx_r >>> it_r;
    at = $signed(CW'(sbtc_pkg::atan_q30(it_r)));
    if (state_r == S_SIN) begin
      if (!cz_r[CW-1]) begin
        cx_nxt = cx_r - dx;
        cy_nxt = cy_r + dy;
        cz_nxt = cz_r - at;
      end else begin
        cx_nxt = cx_r + dx;
        cy_nxt = cy_r - dy;
        cz_nxt = cz_r + at;
      end
    end else begin
      if (!cy_r[CW-1]) begin
        cx_nxt = cx_r + dx;
        cy_nxt = cy_r - dy;
        cz_nxt = cz_r + at;
      end else begin
        cx_nxt = cx_r - dx;
        cy_nxt = cy_r + dy;
        cz_nxt = cz_r - at;
      end
    end
  end

  // drive clamp, sum clamp, root step and output rounding
  logic signed [PW-1:0]   drv;
  logic signed [CW-1:0]   ang, zr, zs, oval_w;
  logic signed [SUMW-1:0] sum_w, sum_c;
  logic signed [CW-1:0]   mag;
  logic [RW-1:0]          rb, res_nxt, n_nxt;
  logic signed [SAMPLE_WIDTH-1:0] oval;

  always_comb begin
    drv = mul_prod >>> DSH;
    if (drv > DRV_MAX) begin
      ang = sbtc_pkg::HALF_PI_Q30;
    end else if (drv < DRV_MIN) begin
      ang = -sbtc_pkg::HALF_PI_Q30;
    end else begin
      ang = drv[CW-1:0];
    end

    sum_w = sum_r + SUMW'(mul_prod >>> 16);
    sum_c = sum_w;
    if (sum_w > SUM_MAX) sum_c = SUM_MAX;
    if (sum_w < SUM_MIN) sum_c = SUM_MIN;
    mag = sum_c[SUMW-1] ? -sum_c[CW-1:0] : sum_c[CW-1:0];

    rb = res_r + bit_r;
    if (n_r >= rb) begin
      n_nxt   = n_r - rb;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      n_nxt   = n_r;
      res_nxt = res_r >> 1;
    end

    zr = cz_nxt + RND;
    zs = zr >>> OSH;
    oval_w = zs;
    if (zs > OUT_MAX) oval_w = OUT_MAX;
    if (zs < OUT_MIN) oval_w = OUT_MIN;
    oval = oval_w[SAMPLE_WIDTH-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      tog_r       <= 1'b0;
      ch_r        <= 1'b0;
      fsel_r      <= 1'b0;
      gsel_r      <= 1'b0;
      it_r        <= '0;
    end else begin
      mul_go_r    <= 1'b0;
      out_valid_r <= out_valid_r & out_stall;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            xl_r     <= in_left_in;
            xr_r     <= in_right_in;
            ch_r     <= 1'b0;
            mul_a_r  <= AW'(in_left_in);
            mul_b_r  <= $signed(BW'(ig_r));
            mul_go_r <= 1'b1;
            state_r  <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          if (mul_done) begin
            cx_r    <= sbtc_pkg::INV_GAIN_Q30;
            cy_r    <= '0;
            cz_r    <= ang;
            it_r    <= '0;
            state_r <= S_SIN;
          end
        end
        S_SIN: begin
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= cz_nxt;
          it_r <= it_r + 1'b1;
          if (it_r == LAST_STEP) begin
            s_r      <= cy_nxt;
            fsel_r   <= 1'b0;
            mul_a_r  <= AW'(cy_nxt);
            mul_b_r  <= BW'(ta0_r);
            mul_go_r <= 1'b1;
            state_r  <= S_LP_P;
          end
        end
        S_LP_P: begin
          if (mul_done) begin
            p_r      <= mul_prod;
            y_r      <= y_nxt;
            mul_a_r  <= AW'(y_nxt);
            mul_b_r  <= BW'(b1_sel);
            mul_go_r <= 1'b1;
            state_r  <= S_LP_Y1;
          end
        end
        S_LP_Y1: begin
          if (mul_done) begin
            mul_a_r  <= AW'(y_r);
            mul_b_r  <= BW'(b2_sel);
            mul_go_r <= 1'b1;
            state_r  <= S_LP_Y2;
          end
        end
        S_LP_Y2: begin
          if (mul_done) begin
            mul_go_r <= 1'b1;
            if (!fsel_r) begin
              lh_r    <= y_r;
              fsel_r  <= 1'b1;
              mul_a_r <= AW'(s_r);
              mul_b_r <= BW'(ba0_r);
              state_r <= S_LP_P;
            end else begin
              lb_r    <= y_r;
              gsel_r  <= 1'b0;
              mul_a_r <= AW'(s_r) - AW'(lh_r);
              mul_b_r <= $signed(BW'(tg_r));
              state_r <= S_GAIN;
            end
          end
        end
        S_GAIN: begin
          if (mul_done) begin
            mul_go_r <= 1'b1;
            if (!gsel_r) begin
              sum_r   <= SUMW'(mul_prod >>> 16);
              gsel_r  <= 1'b1;
              mul_a_r <= AW'(lb_r);
              mul_b_r <= $signed(BW'(bg_r));
            end else begin
              sc_r    <= sum_c[CW-1:0];
              mul_a_r <= AW'(mag);
              mul_b_r <= BW'(mag);
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (mul_done) begin
            n_r     <= ONE_Q60 - RW'(mul_prod);
            res_r   <= '0;
            bit_r   <= ONE_Q60;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          n_r   <= n_nxt;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r == RW'(1)) begin
            cx_r    <= $signed(res_nxt[CW-1:0]);
            cy_r    <= sc_r;
            cz_r    <= '0;
            it_r    <= '0;
            state_r <= S_ASIN;
          end
        end
        S_ASIN: begin
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= cz_nxt;
          it_r <= it_r + 1'b1;
          if (it_r == LAST_STEP) begin
            if (!ch_r) begin
              ol_r     <= oval;
              ch_r     <= 1'b1;
              mul_a_r  <= AW'(xr_r);
              mul_b_r  <= $signed(BW'(ig_r));
              mul_go_r <= 1'b1;
              state_r  <= S_DRIVE;
            end else begin
              or_r    <= oval;
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            left_out_r  <= ol_r;
            right_out_r <= or_r;
            tog_r       <= ~tog_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_left_out  = left_out_r;
  assign out_right_out = right_out_r;

endmodule

// ===== hw/rtl/sbtc_checker.sv =====
// port-level checks for the tone stage, bound to the top level
// uses no package; attaches to stereo_baxandall_tone_stage_top
module sbtc_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] out_left_out,
  input logic [SAMPLE_WIDTH-1:0] out_right_out
);

  // nothing is shown right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted request blocks the input until it is worked off
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a request");

  // a request accepted while no result is shown is not followed at once by a result
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result without work");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_left_out)
                                  && $stable(out_right_out)))
    else $error("stalled result changed");

endmodule

bind stereo_baxandall_tone_stage_top sbtc_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sbtc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_left_out  (out_left_out),
  .out_right_out (out_right_out)
);

// ===== tb/stereo_baxandall_tone_stage_top_tb.sv =====
// testbench for the stereo tone stage: directed table, then random phases over several settings
// depends on sbtc_pkg and stereo_baxandall_tone_stage_top; checks against its own bit-exact predictor
`timescale 1ns / 100ps

module stereo_baxandall_tone_stage_top_tb;
  import sbtc_pkg::*;

  localparam int SW = 24;
  localparam int STW = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_LIMIT = 40000;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } pair_t;

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    bit has_exp;
    logic signed [SW-1:0] exp_left;
    logic signed [SW-1:0] exp_right;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_left_in = '0;
  logic signed [SW-1:0] in_right_in = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [SW-1:0] out_left_out;
  logic signed [SW-1:0] out_right_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  stereo_baxandall_tone_stage_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_in(in_left_in), .in_right_in(in_right_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [GAIN_W-1:0] m_in_gain, m_tr_gain, m_bs_gain;
  logic [COEF_W-1:0] m_tr_a0, m_tr_b1, m_bs_a0, m_bs_b1;
  longint tr_st[8];
  longint bs_st[8];
  bit bank_sel;

  pair_t tone_q[$];
  bit typed_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  function automatic longint sat_w(longint v, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // floor(a*b / 2^sh), split to stay inside 64 bits
  function automatic longint mul_floor(longint a, longint b, int sh);
    longint ah, al;
    ah = a >>> sh;
    al = a - ah * (64'sd1 <<< sh);
    return ah * b + ((al * b) >>> sh);
  endfunction

  function automatic longint atan_at(int i);
    return longint'({32'd0, atan_q30(i[STEP_W-1:0])});
  endfunction

  function automatic longint sine_fx(longint ang);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = ang;
    if (z > 64'sd1686629713) z = 64'sd1686629713;
    if (z < -64'sd1686629713) z = -64'sd1686629713;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_at(i);
      end else begin
        x += dx; y -= dy; z += atan_at(i);
      end
    end
    return y;
  endfunction

  function automatic longint unsigned root_fx(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 60;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint arcsine_fx(longint s);
    longint unsigned m;
    longint x, y, z, dx, dy;
    m = (s < 0) ? -s : s;
    x = longint'(root_fx((64'd1 << 60) - m * m));
    y = s;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_at(i);
      end else begin
        x -= dx; y += dy; z -= atan_at(i);
      end
    end
    return z;
  endfunction

  function automatic longint biquad_lp(inout longint s0, inout longint s1,
                                       input longint x, input longint a0, input longint b1);
    longint b2, y;
    b2 = sat_w(4 * a0 - (64'sd1 <<< 30) - b1, 32);
    y = sat_w(mul_floor(x, a0, 30) + s0, STW);
    s0 = sat_w(mul_floor(x, 2 * a0, 30) - mul_floor(y, b1, 30) + s1, STW);
    s1 = sat_w(mul_floor(x, a0, 30) - mul_floor(y, b2, 30), STW);
    return y;
  endfunction

  // expected pair for one accepted sample pair; advances the filter banks
  function automatic pair_t tone_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
    pair_t res;
    longint x, s, lh, lb, sum, z;
    int base;
    logic signed [SW-1:0] o;
    for (int ch = 0; ch < 2; ch++) begin
      x = (ch == 0) ? longint'(l) : longint'(r);
      s = sine_fx((x * longint'({45'd0, m_in_gain})) >>> (SW - 15));
      base = (bank_sel ? 0 : 4) + ch * 2;
      lh = biquad_lp(tr_st[base], tr_st[base+1], s,
                     longint'(signed'(m_tr_a0)), longint'(signed'(m_tr_b1)));
      lb = biquad_lp(bs_st[base], bs_st[base+1], s,
                     longint'(signed'(m_bs_a0)), longint'(signed'(m_bs_b1)));
      sum = mul_floor(s - lh, longint'({45'd0, m_tr_gain}), 16)
          + mul_floor(lb, longint'({45'd0, m_bs_gain}), 16);
      if (sum > 64'sd1073731086) sum = 64'sd1073731086;
      if (sum < -64'sd1073731086) sum = -64'sd1073731086;
      z = arcsine_fx(sum) + (64'sd1 <<< (32 - SW - 1));
      o = sat_w(z >>> (32 - SW), SW);
      if (ch == 0) res.left = o;
      else res.right = o;
    end
    bank_sel = ~bank_sel;
    return res;
  endfunction

  task automatic reset_model();
    m_in_gain = GAIN_RST;
    m_tr_gain = GAIN_RST;
    m_bs_gain = GAIN_RST;
    m_tr_a0 = A0_RST;
    m_tr_b1 = B1_RST;
    m_bs_a0 = A0_RST;
    m_bs_b1 = B1_RST;
    for (int i = 0; i < 8; i++) begin
      tr_st[i] = 0;
      bs_st[i] = 0;
    end
    bank_sel = 1'b0;
  endtask

  // accepted requests on all three channels, result check, watchdog
  always @(posedge clk) begin
    pair_t exp_p;
    bit any;
    if (rst_n) begin
      any = 1'b0;
      if (cfg_valid && cfg_ready) begin
        any = 1'b1;
        case (cfg_index)
          REG_INPUT_GAIN:  m_in_gain = cfg_data[GAIN_W-1:0];
          REG_TREBLE_GAIN: m_tr_gain = cfg_data[GAIN_W-1:0];
          REG_BASS_GAIN:   m_bs_gain = cfg_data[GAIN_W-1:0];
          REG_TREBLE_A0:   m_tr_a0 = cfg_data;
          REG_TREBLE_B1:   m_tr_b1 = cfg_data;
          REG_BASS_A0:     m_bs_a0 = cfg_data;
          REG_BASS_B1:     m_bs_b1 = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        any = 1'b1;
        tone_q.push_back(tone_pair(in_left_in, in_right_in));
      end
      if (out_valid && !out_stall) begin
        any = 1'b1;
        if (tone_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d %0d", out_left_out, out_right_out);
        end else begin
          exp_p = tone_q.pop_front();
          if (exp_p.left !== out_left_out || exp_p.right !== out_right_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d, got %0d %0d",
                       exp_p.left, exp_p.right, out_left_out, out_right_out);
          end
        end
      end
      idle_cycles = any ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[stereo_baxandall_tone_stage_top] ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // result side: random stall, plus one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk) ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r, bit idle_ok);
    bit ok;
    int g;
    in_valid <= 1'b1;
    in_left_in <= l;
    in_right_in <= r;
    do begin
      @(negedge clk) ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    g = idle_ok ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (tone_q.size() == 0);
    @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom();
    if (r < 75) return 24'sh7FFFFF;
    if (r < 85) return -24'sh800000;
    return $signed($urandom_range(0, 4096)) - 2048;
  endfunction

  task automatic write_all(logic [CFG_DATA_W-1:0] ig, logic [CFG_DATA_W-1:0] tg,
                           logic [CFG_DATA_W-1:0] bg, logic [CFG_DATA_W-1:0] ta,
                           logic [CFG_DATA_W-1:0] tb, logic [CFG_DATA_W-1:0] ba,
                           logic [CFG_DATA_W-1:0] bb);
    write_reg(REG_INPUT_GAIN, ig);
    write_reg(REG_TREBLE_GAIN, tg);
    write_reg(REG_BASS_GAIN, bg);
    write_reg(REG_TREBLE_A0, ta);
    write_reg(REG_TREBLE_B1, tb);
    write_reg(REG_BASS_A0, ba);
    write_reg(REG_BASS_B1, bb);
  endtask

  row_t dir_tab[$];

  initial begin
    row_t rw;
    int cnt;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: silence, extremes, sign patterns, small values
    dir_tab = '{
      '{24'sd0, 24'sd0, 0, 0, 0},
      '{24'sd0, 24'sd0, 0, 0, 0},
      '{24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0},
      '{-24'sh800000, -24'sh800000, 0, 0, 0},
      '{24'sh7FFFFF, -24'sh800000, 0, 0, 0},
      '{-24'sh800000, 24'sh7FFFFF, 0, 0, 0},
      '{24'sd1, -24'sd1, 0, 0, 0},
      '{-24'sd1, 24'sd1, 0, 0, 0},
      '{24'sh400000, -24'sh400000, 0, 0, 0},
      '{24'sh555555, 24'shAAAAAA, 0, 0, 0},
      '{24'shAAAAAA, 24'sh555555, 0, 0, 0},
      '{24'sh123456, 24'shFEDCBA, 0, 0, 0},
      '{24'sd0, 24'sh7FFFFF, 0, 0, 0},
      '{24'sd0, 24'sd0, 0, 0, 0},
      '{24'sd0, 24'sd0, 0, 0, 0},
      '{24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0}
    };
    foreach (dir_tab[i]) begin
      rw = dir_tab[i];
      send_pair(rw.left, rw.right, 1'b1);
    end
    drain();

    // phase loop over settings: reset values, extremes, random values, then reset values with a spare write
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: ;
        1: write_all(32'd262144, 32'd262144, 32'd262144,
                     32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        2: write_all(32'd0, 32'd524287, 32'd0,
                     32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        3: write_all(32'd524287, 32'd0, 32'd524287, 32'd0, 32'd0, 32'd0, 32'd0);
        8: begin
          write_all(GAIN_RST, GAIN_RST, GAIN_RST, A0_RST, B1_RST, A0_RST, B1_RST);
          write_reg(REG_SPARE, $urandom());
        end
        default: write_all($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom());
      endcase
      cnt = 0;
      repeat (115) begin
        if (ph == 1 && cnt == 20) hold_req = 1'b1;
        if (ph == 2 && cnt == 50) drain();
        send_pair(rand_sample(), rand_sample(), !(ph == 1 && cnt >= 20 && cnt < 30));
        cnt++;
      end
      drain();
    end

    repeat (1000) @(posedge clk);
    if (mismatches == 0 && tone_q.size() == 0) begin
      $display("[stereo_baxandall_tone_stage_top] OK");
    end else begin
      $display("[stereo_baxandall_tone_stage_top] ERROR");
    end
    $finish;
  end

endmodule
